// ----- src/cmt_pkg.sv -----
package cmt_pkg;

  // Widths of the fields that do not follow from any module parameter
  localparam int LINE_SHIFT_W = 4;
  localparam int LINES_W      = 8;
  localparam int OUT_LINE_W   = 32;
  localparam int CNT_W        = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_IN_USE = 2'd1;

  localparam logic [LINE_SHIFT_W-1:0] LINE_SHIFT_RST   = 4'd6;
  localparam logic [LINES_W-1:0]      LINES_IN_USE_RST = 8'd128;

  typedef logic [CNT_W-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
  endfunction

endpackage

// ----- src/cmt_store.sv -----
module cmt_store
  import cmt_pkg::*;
#(
  parameter int MAX_LINES  = 128,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd,
  input  logic [ADDR_WIDTH-1:0]             line,
  input  logic [$clog2(MAX_LINES+1)-1:0]    cap,
  output logic                              hit
);

  localparam int AGE_W = $clog2(MAX_LINES);
  localparam int CAP_W = $clog2(MAX_LINES + 1);

  logic [ADDR_WIDTH-1:0] tag_r   [MAX_LINES];
  logic [AGE_W-1:0]      age_r   [MAX_LINES];
  logic [AGE_W-1:0]      age_nxt [MAX_LINES];
  logic [MAX_LINES-1:0]  valid_r, valid_nxt;
  logic [MAX_LINES-1:0]  present, match_oh, kept, vacant_oh;
  logic [AGE_W-1:0]      hit_age;

  // Parallel tag compare; entries ranked at or beyond capacity do not count
  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      present[i] = valid_r[i] && (CAP_W'(age_r[i]) < cap) && (tag_r[i] == line);
    end
  end

  assign match_oh = present & (~present + MAX_LINES'(1));
  assign hit      = |present;

  always_comb begin
    hit_age = '0;
    for (int i = 0; i < MAX_LINES; i++) begin
      if (match_oh[i]) begin
        hit_age = hit_age | age_r[i];
      end
    end
  end

  // Recency update and dropping of entries pushed out of capacity
  always_comb begin
    for (int i = 0; i < MAX_LINES; i++) begin
      kept[i]    = valid_r[i];
      age_nxt[i] = age_r[i];
      if (valid_r[i]) begin
        if (hit) begin
          if (CAP_W'(age_r[i]) >= cap) begin
            kept[i] = 1'b0;
          end else if (age_r[i] < hit_age) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end else begin
          if (CAP_W'(age_r[i]) + CAP_W'(1) >= cap) begin
            kept[i] = 1'b0;
          end else begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
      end
      if (match_oh[i]) begin
        age_nxt[i] = '0;
      end
    end
  end

  // Lowest free slot after the update takes the new line on a miss
  assign vacant_oh = ~kept & (kept + MAX_LINES'(1));
  assign valid_nxt = hit ? kept : (kept | vacant_oh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_LINES; i++) begin
        age_r[i] <= '0;
      end
    end else if (upd) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < MAX_LINES; i++) begin
        if (!hit && vacant_oh[i]) begin
          age_r[i] <= '0;
        end else begin
          age_r[i] <= age_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LINES; i++) begin
      if (upd && !hit && vacant_oh[i]) begin
        tag_r[i] <= line;
      end
    end
  end

endmodule

// ----- src/cache_miss_tracker.sv -----
// Cache miss tracker: fully associative line store with true LRU replacement.
// Input channel (in_valid/in_ready, in_access_address) takes one byte address
// per transaction. The address is aligned down to a line of 2^line_shift bytes
// and looked up in all stored lines at once; a hit makes the line the most
// recently used, a miss installs it and evicts the least recently used line
// once lines_in_use lines are present.
// Output channel (out_valid/out_ready) returns one transaction per input:
// hit flag, aligned line address and saturating access and miss counts.
// An accepted input waits in the input register; its result is offered from the result register.
// Throughput: one transaction per cycle while the receiver does not stall; the
// lookup and recency update for an access are combinational, between the input
// and result registers.
// When the receiver stalls, the result register holds and the input register
// can still take one more transaction; after that in_ready drops.
// Configuration (cfg_valid/cfg_ready) is always ready and should be written
// only while no transaction is in flight.
// Reset empties the line store, clears both counters and restores a line size
// of 64 bytes and a capacity of 128 lines. No clearing pass is needed.
module cache_miss_tracker
  import cmt_pkg::*;
#(
  parameter int MAX_LINES  = 128,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADDR_WIDTH-1:0]   in_access_address,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [OUT_LINE_W-1:0]   out_aligned_line,
  output logic [CNT_W-1:0]        out_total_accesses,
  output logic [CNT_W-1:0]        out_total_misses,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CAP_W = $clog2(MAX_LINES + 1);
  localparam int CMP_W = (CAP_W > LINES_W) ? CAP_W : LINES_W;
  localparam int EXT_W = ADDR_WIDTH + OUT_LINE_W;

  logic [LINE_SHIFT_W-1:0] line_shift_r;
  logic [LINES_W-1:0]      lines_in_use_r;

  logic                    in_vld_r;
  logic [ADDR_WIDTH-1:0]   addr_r;
  logic                    fire;

  logic [CMP_W-1:0]        lines_ext;
  logic [CAP_W-1:0]        cap;
  logic [ADDR_WIDTH-1:0]   line;
  logic [EXT_W-1:0]        line_ext;
  logic                    hit;

  cnt_t                    acc_r, miss_r, acc_nxt, miss_nxt;
  logic                    out_vld_r;
  logic                    hit_r;
  logic [OUT_LINE_W-1:0]   line_r;

  // Configuration writes: always accepted, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_shift_r   <= LINE_SHIFT_RST;
      lines_in_use_r <= LINES_IN_USE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_SHIFT:   line_shift_r   <= cfg_data[LINE_SHIFT_W-1:0];
        REG_LINES_IN_USE: lines_in_use_r <= cfg_data[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register whenever the lookup stage moves on
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_r <= in_access_address;
    end
  end

  // Capacity: zero acts as one, anything above the store size saturates
  assign lines_ext = CMP_W'(lines_in_use_r);

  always_comb begin
    if (lines_ext == '0) begin
      cap = CAP_W'(1);
    end else if (lines_ext > CMP_W'(MAX_LINES)) begin
      cap = CAP_W'(MAX_LINES);
    end else begin
      cap = CAP_W'(lines_ext);
    end
  end

  // Drop the offset bits within the line
  assign line     = addr_r & ({ADDR_WIDTH{1'b1}} << line_shift_r);
  assign line_ext = EXT_W'(line);

  cmt_store #(
    .MAX_LINES  (MAX_LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (fire),
    .line  (line),
    .cap   (cap),
    .hit   (hit)
  );

  // Counters include the access being reported
  assign acc_nxt  = sat_inc(acc_r);
  assign miss_nxt = hit ? miss_r : sat_inc(miss_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      miss_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        acc_r  <= acc_nxt;
        miss_r <= miss_nxt;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      hit_r  <= hit;
      line_r <= line_ext[OUT_LINE_W-1:0];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_hit            = hit_r;
  assign out_aligned_line   = line_r;
  assign out_total_accesses = acc_r;
  assign out_total_misses   = miss_r;

endmodule
